// ===== src/esp_session_table_with_aging_defines.svh =====
// Assertion macros for the session table.
`ifndef ESP_SESSION_TABLE_WITH_AGING_DEFINES_SVH
`define ESP_SESSION_TABLE_WITH_AGING_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define ESTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESTA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/esta_pkg.sv =====
// Types and constants shared by the session table modules.
package esta_pkg;

	localparam int PADDR_W = 4;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
	localparam logic [IDX_W-1:0] REG_SPI_VALUE    = 2'd1;
	localparam logic [IDX_W-1:0] REG_INIT_SEQ     = 2'd2;

	localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd60;
	localparam logic [31:0] RST_SPI_VALUE    = 32'd5000;
	localparam logic [31:0] RST_INIT_SEQ     = 32'd1;

	localparam logic [15:0] HEADER_BYTES = 16'd8;

	typedef enum logic [1:0] {
		OP_ESP_RX = 2'd0,
		OP_REPLY  = 2'd1,
		OP_TICK   = 2'd2,
		OP_SWEEP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_HIT      = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_SHORT    = 3'd3,
		STAT_HEADER   = 3'd4,
		STAT_BAD_SLOT = 3'd5,
		STAT_TICKED   = 3'd6,
		STAT_SWEPT    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_REPLY,
		S_SWEEP
	} state_t;

	typedef struct packed {
		op_t         operation;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [15:0] packet_length;
		logic [3:0]  slot_index;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic [63:0] dest_high;
		logic [63:0] dest_low;
		logic [31:0] esp_spi;
		logic [31:0] esp_sequence;
		logic [4:0]  removed_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] idle_timeout;
		logic [31:0] spi_value;
		logic        seq_load;
		logic [31:0] seq_value;
	} cfg_t;

endpackage

// ===== src/esta_cfg.sv =====
// APB configuration registers of the session table.
module esta_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [esta_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output esta_pkg::cfg_t               cfg
);

	logic [15:0]                idle_timeout_q;
	logic [31:0]                spi_value_q;
	logic [31:0]                init_seq_q;
	logic                       wr;
	logic [esta_pkg::IDX_W-1:0] reg_idx;

	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[esta_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= esta_pkg::RST_IDLE_TIMEOUT;
			spi_value_q    <= esta_pkg::RST_SPI_VALUE;
			init_seq_q     <= esta_pkg::RST_INIT_SEQ;
		end else if (wr) begin
			unique case (reg_idx)
				esta_pkg::REG_IDLE_TIMEOUT: idle_timeout_q <= pwdata[15:0];
				esta_pkg::REG_SPI_VALUE:    spi_value_q    <= pwdata;
				esta_pkg::REG_INIT_SEQ:     init_seq_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			esta_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, idle_timeout_q};
			esta_pkg::REG_SPI_VALUE:    prdata = spi_value_q;
			esta_pkg::REG_INIT_SEQ:     prdata = init_seq_q;
			default:                    prdata = '0;
		endcase
	end

	// sequence counter in the top level loads on the same edge as the write
	assign cfg.idle_timeout = idle_timeout_q;
	assign cfg.spi_value    = spi_value_q;
	assign cfg.seq_load     = wr && (reg_idx == esta_pkg::REG_INIT_SEQ);
	assign cfg.seq_value    = pwdata;

endmodule

// ===== src/esp_session_table_with_aging.sv =====
// Session table keyed by client IPv6 address, with idle aging and ESP header output.
//
//   channel   handshake                 payload
//   request   start, busy (in)          request (esta_pkg::req_t)
//   result    done strobe (out)         result  (esta_pkg::rsp_t)
//   config    psel/penable/pwrite/...   pwdata, prdata, 32 bits
//
// Tick, short packet and bad slot: answered in the cycle after acceptance, busy stays low.
// Reply reads the entry memory once. Sweep and lookup step through the slots from slot 0, with
// a lookup ending early on a hit, one entry per cycle through the memory port.
// Reset clears the valid flops at once; there is no clearing pass.
// done is high for one cycle per request; the receiver cannot stall.
`include "esp_session_table_with_aging_defines.svh"

module esp_session_table_with_aging #(
	parameter int SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  esta_pkg::req_t               request,
	output logic                         done,
	output esta_pkg::rsp_t               result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [esta_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	esta_pkg::cfg_t   cfg;
	esta_pkg::state_t state_q, state_d;
	esta_pkg::req_t   req_q;
	esta_pkg::rsp_t   result_q, res_d;
	logic             done_q;

	logic [127:0]     addr_mem [SLOTS];
	logic [31:0]      seen_mem [SLOTS];
	logic [127:0]     addr_rd_s1;
	logic [31:0]      seen_rd_s1;
	logic [SW-1:0]    cmp_idx_s1;
	logic [SW-1:0]    rd_addr;
	logic [SW-1:0]    wr_idx;

	logic [SLOTS-1:0] entry_valid_q;
	logic             free_fnd_q;
	logic [SW-1:0]    free_idx_q;
	logic [CW-1:0]    rm_cnt_q;
	logic [31:0]      seconds_q;
	logic [31:0]      seq_q;

	logic accept, last, cur_valid, match, expired, in_range, slot_ok, too_short;
	logic ins_ok;
	logic [SW-1:0] ins_idx;
	logic res_fire, addr_we, seen_we, valid_set, valid_clr, tick, seq_inc;
	logic free_cap, rm_inc;

	esta_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;
	assign busy   = (state_q != esta_pkg::S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign last      = (cmp_idx_s1 == SW'(SLOTS - 1));
	assign cur_valid = entry_valid_q[cmp_idx_s1];
	assign match     = cur_valid && (addr_rd_s1 == {req_q.addr_high, req_q.addr_low});
	// idle time wraps modulo 2^32
	assign expired   = cur_valid && ((seconds_q - seen_rd_s1) > {16'd0, cfg.idle_timeout});
	assign in_range  = int'(request.slot_index) < SLOTS;
	assign slot_ok   = in_range && entry_valid_q[SW'(request.slot_index)];
	assign too_short = request.packet_length <= esta_pkg::HEADER_BYTES;
	assign ins_ok    = free_fnd_q || !cur_valid;
	assign ins_idx   = free_fnd_q ? free_idx_q : cmp_idx_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			esta_pkg::S_IDLE: begin
				if (accept) begin
					unique case (request.operation)
						esta_pkg::OP_ESP_RX: state_d = too_short ? esta_pkg::S_IDLE
							: esta_pkg::S_LOOKUP;
						esta_pkg::OP_REPLY:  state_d = slot_ok ? esta_pkg::S_REPLY
							: esta_pkg::S_IDLE;
						esta_pkg::OP_TICK:   state_d = esta_pkg::S_IDLE;
						esta_pkg::OP_SWEEP:  state_d = esta_pkg::S_SWEEP;
						default:             state_d = esta_pkg::S_IDLE;
					endcase
				end
			end
			esta_pkg::S_LOOKUP: if (match || last) state_d = esta_pkg::S_IDLE;
			esta_pkg::S_REPLY:  state_d = esta_pkg::S_IDLE;
			esta_pkg::S_SWEEP:  if (last) state_d = esta_pkg::S_IDLE;
			default:            state_d = esta_pkg::S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		res_d     = '0;
		res_fire  = 1'b0;
		addr_we   = 1'b0;
		seen_we   = 1'b0;
		wr_idx    = cmp_idx_s1;
		valid_set = 1'b0;
		valid_clr = 1'b0;
		tick      = 1'b0;
		seq_inc   = 1'b0;
		free_cap  = 1'b0;
		rm_inc    = 1'b0;
		rd_addr   = last ? '0 : cmp_idx_s1 + SW'(1);
		unique case (state_q)
			esta_pkg::S_IDLE: begin
				rd_addr = (request.operation == esta_pkg::OP_REPLY && in_range)
					? SW'(request.slot_index) : '0;
				if (accept) begin
					unique case (request.operation)
						esta_pkg::OP_ESP_RX: begin
							if (too_short) begin
								res_fire     = 1'b1;
								res_d.status = esta_pkg::STAT_SHORT;
							end
						end
						esta_pkg::OP_REPLY: begin
							if (!slot_ok) begin
								res_fire     = 1'b1;
								res_d.status = esta_pkg::STAT_BAD_SLOT;
								res_d.slot   = request.slot_index;
							end
						end
						esta_pkg::OP_TICK: begin
							res_fire     = 1'b1;
							res_d.status = esta_pkg::STAT_TICKED;
							tick         = 1'b1;
						end
						default: ;
					endcase
				end
			end
			esta_pkg::S_LOOKUP: begin
				free_cap = !free_fnd_q && !cur_valid;
				priority if (match) begin
					res_fire     = 1'b1;
					res_d.status = esta_pkg::STAT_HIT;
					res_d.slot   = 4'(cmp_idx_s1);
					seen_we      = 1'b1;
				end else if (last && ins_ok) begin
					res_fire     = 1'b1;
					res_d.status = esta_pkg::STAT_INSERTED;
					res_d.slot   = 4'(ins_idx);
					wr_idx       = ins_idx;
					addr_we      = 1'b1;
					seen_we      = 1'b1;
					valid_set    = 1'b1;
				end else if (last) begin
					res_fire     = 1'b1;
					res_d.status = esta_pkg::STAT_FULL;
				end else begin
					// keep scanning
				end
			end
			esta_pkg::S_REPLY: begin
				res_fire           = 1'b1;
				res_d.status       = esta_pkg::STAT_HEADER;
				res_d.slot         = 4'(cmp_idx_s1);
				res_d.dest_high    = addr_rd_s1[127:64];
				res_d.dest_low     = addr_rd_s1[63:0];
				res_d.esp_spi      = cfg.spi_value;
				res_d.esp_sequence = seq_q;
				seq_inc            = 1'b1;
				seen_we            = 1'b1;
			end
			esta_pkg::S_SWEEP: begin
				valid_clr = expired;
				rm_inc    = expired;
				if (last) begin
					res_fire            = 1'b1;
					res_d.status        = esta_pkg::STAT_SWEPT;
					res_d.removed_count = 5'(rm_cnt_q + CW'(expired));
				end
			end
			default: ;
		endcase
	end

	// entry memories, registered read port
	always_ff @(posedge clk) begin
		if (addr_we) addr_mem[wr_idx] <= {req_q.addr_high, req_q.addr_low};
		if (seen_we) seen_mem[wr_idx] <= seconds_q;
		addr_rd_s1 <= addr_mem[rd_addr];
		seen_rd_s1 <= seen_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= request;
		if (free_cap) free_idx_q <= cmp_idx_s1;
		if (res_fire) result_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= esta_pkg::S_IDLE;
			done_q        <= 1'b0;
			cmp_idx_s1    <= '0;
			entry_valid_q <= '0;
			free_fnd_q    <= 1'b0;
			rm_cnt_q      <= '0;
			seconds_q     <= '0;
			seq_q         <= esta_pkg::RST_INIT_SEQ;
		end else begin
			state_q    <= state_d;
			done_q     <= res_fire;
			cmp_idx_s1 <= rd_addr;
			if (valid_set) entry_valid_q[wr_idx] <= 1'b1;
			if (valid_clr) entry_valid_q[cmp_idx_s1] <= 1'b0;
			if (accept) begin
				free_fnd_q <= 1'b0;
				rm_cnt_q   <= '0;
			end else begin
				if (free_cap) free_fnd_q <= 1'b1;
				if (rm_inc) rm_cnt_q <= rm_cnt_q + CW'(1);
			end
			if (tick) seconds_q <= seconds_q + 32'd1;
			if (cfg.seq_load) seq_q <= cfg.seq_value;
			else if (seq_inc) seq_q <= seq_q + 32'd1;
		end
	end

	`ESTA_ASSERT_NXT(a_accept_progress, accept, done || busy, "request neither answered nor in work")
	`ESTA_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while still busy")
	`ESTA_ASSERT_NXT(a_tick_count, tick, seconds_q == $past(seconds_q) + 32'd1, "tick not counted")

endmodule

// ===== tb/sv/esp_session_table_with_aging_test.sv =====
// Self-checking testbench for the ESP session table: directed and random requests.
`timescale 1ns / 100ps

module esp_session_table_with_aging_test;

	localparam int NSLOT = 16;
	localparam int POOL = 24;
	localparam int LATENCY = NSLOT + 4;
	localparam logic [esta_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	esta_pkg::req_t request = '0;
	logic done;
	esta_pkg::rsp_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [esta_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	esp_session_table_with_aging u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// shadow copy of the session table and its registers
	logic        sess_valid [NSLOT];
	logic [63:0] sess_high [NSLOT];
	logic [63:0] sess_low [NSLOT];
	logic [31:0] sess_seen [NSLOT];
	logic [31:0] sec_now;
	logic [31:0] seq_ctr;
	logic [15:0] cfg_timeout;
	logic [31:0] cfg_spi;
	logic [31:0] cfg_seq;

	esta_pkg::rsp_t pending_results[$];
	int mismatches = 0;
	int burst_left = 0;
	logic [63:0] pool_high [POOL];
	logic [63:0] pool_low [POOL];

	task automatic clear_shadow();
		for (int i = 0; i < NSLOT; i++) begin
			sess_valid[i] = 1'b0;
			sess_high[i] = '0;
			sess_low[i] = '0;
			sess_seen[i] = '0;
		end
		sec_now = '0;
		seq_ctr = esta_pkg::RST_INIT_SEQ;
		cfg_timeout = esta_pkg::RST_IDLE_TIMEOUT;
		cfg_spi = esta_pkg::RST_SPI_VALUE;
		cfg_seq = esta_pkg::RST_INIT_SEQ;
	endtask

	// expected response for one request; updates the shadow table
	function automatic esta_pkg::rsp_t session_result(esta_pkg::req_t r);
		esta_pkg::rsp_t o;
		int free_slot;
		logic found;
		logic [4:0] removed;
		o = '0;
		free_slot = -1;
		found = 1'b0;
		removed = '0;
		case (r.operation)
			esta_pkg::OP_ESP_RX: begin
				if (r.packet_length <= esta_pkg::HEADER_BYTES) begin
					o.status = esta_pkg::STAT_SHORT;
				end else begin
					for (int i = 0; i < NSLOT && !found; i++) begin
						if (sess_valid[i] && sess_high[i] == r.addr_high &&
							sess_low[i] == r.addr_low) begin
							found = 1'b1;
							sess_seen[i] = sec_now;
							o.status = esta_pkg::STAT_HIT;
							o.slot = 4'(i);
						end else if (!sess_valid[i] && free_slot < 0) begin
							free_slot = i;
						end
					end
					if (!found && free_slot < 0) begin
						o.status = esta_pkg::STAT_FULL;
					end else if (!found) begin
						sess_valid[free_slot] = 1'b1;
						sess_high[free_slot] = r.addr_high;
						sess_low[free_slot] = r.addr_low;
						sess_seen[free_slot] = sec_now;
						o.status = esta_pkg::STAT_INSERTED;
						o.slot = 4'(free_slot);
					end
				end
			end
			esta_pkg::OP_REPLY: begin
				o.slot = r.slot_index;
				if (!sess_valid[r.slot_index]) begin
					o.status = esta_pkg::STAT_BAD_SLOT;
				end else begin
					sess_seen[r.slot_index] = sec_now;
					o.status = esta_pkg::STAT_HEADER;
					o.dest_high = sess_high[r.slot_index];
					o.dest_low = sess_low[r.slot_index];
					o.esp_spi = cfg_spi;
					o.esp_sequence = seq_ctr;
					seq_ctr = seq_ctr + 32'd1;
				end
			end
			esta_pkg::OP_TICK: begin
				sec_now = sec_now + 32'd1;
				o.status = esta_pkg::STAT_TICKED;
			end
			default: begin
				// idle time is taken modulo 2^32
				for (int i = 0; i < NSLOT; i++) begin
					if (sess_valid[i] && (sec_now - sess_seen[i]) > {16'd0, cfg_timeout}) begin
						sess_valid[i] = 1'b0;
						removed = removed + 5'd1;
					end
				end
				o.status = esta_pkg::STAT_SWEPT;
				o.removed_count = removed;
			end
		endcase
		return o;
	endfunction

	function automatic logic [31:0] register_value(logic [esta_pkg::IDX_W-1:0] idx);
		case (idx)
			esta_pkg::REG_IDLE_TIMEOUT: return {16'd0, cfg_timeout};
			esta_pkg::REG_SPI_VALUE:    return cfg_spi;
			esta_pkg::REG_INIT_SEQ:     return cfg_seq;
			default:                    return '0;
		endcase
	endfunction

	task automatic check_field(input string field, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t %s: expected %0h, got %0h", $time, field, exp_v, act_v);
			mismatches++;
		end
	endtask

	// predicts at acceptance, then checks; same process so a same-edge answer still lines up
	always @(posedge clk) begin
		esta_pkg::rsp_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[esta_pkg::PADDR_W-1:2])
					esta_pkg::REG_IDLE_TIMEOUT: cfg_timeout = pwdata[15:0];
					esta_pkg::REG_SPI_VALUE:    cfg_spi = pwdata;
					esta_pkg::REG_INIT_SEQ: begin
						cfg_seq = pwdata;
						seq_ctr = pwdata;
					end
					default: ;
				endcase
			end
			if (start && !busy)
				pending_results.push_back(session_result(request));
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t result: expected none, got status %0d", $time, result.status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 64'(want.status), 64'(result.status));
					check_field("slot", 64'(want.slot), 64'(result.slot));
					check_field("dest_high", want.dest_high, result.dest_high);
					check_field("dest_low", want.dest_low, result.dest_low);
					check_field("esp_spi", 64'(want.esp_spi), 64'(result.esp_spi));
					check_field("esp_sequence", 64'(want.esp_sequence),
						64'(result.esp_sequence));
					check_field("removed_count", 64'(want.removed_count),
						64'(result.removed_count));
				end
			end
		end
	end

	// one request; returns at the edge that accepts it, start left high
	task automatic issue(input esta_pkg::req_t r);
		int gap_cycles;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_cycles != 0) begin
				start <= 1'b0;
				repeat (gap_cycles) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 1'b0;
		burst_left = 0;
		do begin
			@(posedge clk);
			n++;
		end while ((pending_results.size() != 0 || busy !== 1'b0) && n < 4000);
	endtask

	task automatic reg_write(input logic [esta_pkg::IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= esta_pkg::PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(input logic [esta_pkg::IDX_W-1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= esta_pkg::PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== register_value(idx)) begin
			$display("%0t register %0d: expected %0h, got %0h", $time, idx,
				register_value(idx), prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_registers();
		reg_read_check(esta_pkg::REG_IDLE_TIMEOUT);
		reg_read_check(esta_pkg::REG_SPI_VALUE);
		reg_read_check(esta_pkg::REG_INIT_SEQ);
	endtask

	// upper bits of the timeout write are junk: the register keeps 16 bits
	task automatic program_registers(input logic [15:0] timeout, input logic [31:0] spi,
		input logic [31:0] seq);
		drain();
		reg_write(esta_pkg::REG_IDLE_TIMEOUT, {16'($urandom), timeout});
		reg_write(esta_pkg::REG_SPI_VALUE, spi);
		reg_write(esta_pkg::REG_INIT_SEQ, seq);
		check_registers();
	endtask

	function automatic esta_pkg::req_t make_req(esta_pkg::op_t op, logic [63:0] high,
		logic [63:0] low, logic [15:0] len, logic [3:0] slot);
		esta_pkg::req_t r;
		r.operation = op;
		r.addr_high = high;
		r.addr_low = low;
		r.packet_length = len;
		r.slot_index = slot;
		return r;
	endfunction

	task automatic test_basic_requests();
		check_registers();
		issue(make_req(esta_pkg::OP_TICK, '0, '0, '0, '0));
		issue(make_req(esta_pkg::OP_ESP_RX, '0, '0, 16'd0, '0));
		issue(make_req(esta_pkg::OP_ESP_RX, '1, '1, 16'd8, '1));
		issue(make_req(esta_pkg::OP_ESP_RX, '0, '0, 16'd9, '0));
		issue(make_req(esta_pkg::OP_ESP_RX, '1, '1, 16'hFFFF, '1));
		issue(make_req(esta_pkg::OP_ESP_RX, '0, '0, 16'd200, '0));
		issue(make_req(esta_pkg::OP_ESP_RX, '0, '1, 16'd100, '0));   // upper half matches only
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd1));
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd15));
		issue(make_req(esta_pkg::OP_TICK, '0, '0, '0, '0));
		issue(make_req(esta_pkg::OP_SWEEP, '0, '0, '0, '0));
	endtask

	task automatic test_table_full();
		repeat (13)
			issue(make_req(esta_pkg::OP_ESP_RX, {$urandom, $urandom}, {$urandom, $urandom},
				16'd64, '0));
		issue(make_req(esta_pkg::OP_ESP_RX, {$urandom, $urandom}, {$urandom, $urandom},
			16'd64, '0));
		issue(make_req(esta_pkg::OP_ESP_RX, '0, '0, 16'd50, '0));
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd15));
	endtask

	task automatic test_register_extremes();
		program_registers(16'd0, 32'd0, 32'hFFFF_FFFF);
		reg_write(REG_UNUSED, $urandom);
		check_registers();
		issue(make_req(esta_pkg::OP_TICK, '0, '0, '0, '0));
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd0));
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd0));       // sequence wraps
		issue(make_req(esta_pkg::OP_SWEEP, '0, '0, '0, '0));         // zero timeout keeps slot 0 only
		issue(make_req(esta_pkg::OP_TICK, '0, '0, '0, '0));
		issue(make_req(esta_pkg::OP_SWEEP, '0, '0, '0, '0));
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd0));
		program_registers(16'hFFFF, 32'hFFFF_FFFF, 32'd0);
		issue(make_req(esta_pkg::OP_ESP_RX, '1, '1, 16'd9, '0));
		issue(make_req(esta_pkg::OP_REPLY, '0, '0, '0, 4'd0));
		repeat (3) issue(make_req(esta_pkg::OP_TICK, '0, '0, '0, '0));
		issue(make_req(esta_pkg::OP_SWEEP, '0, '0, '0, '0));
	endtask

	// mostly well-formed traffic on a small address pool so hits, fills and aging all occur
	task automatic test_random_traffic(input logic [15:0] timeout, input logic [31:0] spi,
		input logic [31:0] seq, input int count);
		esta_pkg::req_t r;
		int sel;
		int p;
		logic [3:0] s;
		program_registers(timeout, spi, seq);
		for (int i = 0; i < POOL; i++) begin
			pool_high[i] = {$urandom, $urandom};
			pool_low[i] = {$urandom, $urandom};
			if (i > 0) begin
				case ($urandom_range(0, 3))
					0: pool_high[i] = pool_high[i-1];
					1: pool_low[i] = pool_low[i-1];
					default: ;
				endcase
			end
		end
		repeat (count) begin
			r.addr_high = {$urandom, $urandom};
			r.addr_low = {$urandom, $urandom};
			r.packet_length = 16'($urandom);
			r.slot_index = 4'($urandom);
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				r.operation = esta_pkg::OP_ESP_RX;
				if ($urandom_range(0, 9) != 0) begin
					p = $urandom_range(0, POOL - 1);
					r.addr_high = pool_high[p];
					r.addr_low = pool_low[p];
				end
				r.packet_length = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 8)) :
					16'($urandom_range(9, 65535));
			end else if (sel < 72) begin
				r.operation = esta_pkg::OP_REPLY;
				if ($urandom_range(0, 4) != 0) begin
					s = r.slot_index;
					for (int k = 0; k < NSLOT; k++) begin
						if (sess_valid[s]) begin
							r.slot_index = s;
							break;
						end
						s = s + 4'd1;
					end
				end
			end else if (sel < 90) begin
				r.operation = esta_pkg::OP_TICK;
			end else begin
				r.operation = esta_pkg::OP_SWEEP;
			end
			issue(r);
		end
	endtask

	initial begin
		clear_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_table_full();
		test_register_extremes();
		test_random_traffic(16'($urandom_range(1, 6)), $urandom, $urandom, 200);
		test_random_traffic(16'($urandom_range(2, 20)), 32'($urandom_range(0, 4999)),
			32'hFFFF_FFF0 + 32'($urandom_range(0, 8)), 200);
		test_random_traffic(16'd1, $urandom, $urandom, 200);
		drain();
		repeat (LATENCY) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t results: expected %0d more, got none", $time, pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("esp_session_table_with_aging_test: done, clean");
		else
			$display("esp_session_table_with_aging_test: done, errors");
		$finish;
	end

	initial begin
		#(3_000_000);
		$display("esp_session_table_with_aging_test: done, errors");
		$finish;
	end

endmodule
